>>> rtl/sprd_pkg.sv
// Shared types, codes and decode helpers for the sensor payload record decoder.
package sprd_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned ValueW    = 24;
  localparam int unsigned CountW    = 4;
  localparam int unsigned MaxData   = 9;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned InUserW   = 1;
  localparam int unsigned OutUserW  = 1;
  localparam int unsigned OutFieldW = 2 * ByteW + 3 * ValueW + 2;
  localparam int unsigned OutDataW  = ((OutFieldW + 7) / 8) * 8;
  localparam int unsigned QueueDepth = 2;

  // Record type codes
  localparam logic [7:0] TypeDigIn  = 8'h00;
  localparam logic [7:0] TypeDigOut = 8'h01;
  localparam logic [7:0] TypeAnaIn  = 8'h02;
  localparam logic [7:0] TypeAnaOut = 8'h03;
  localparam logic [7:0] TypeLum    = 8'h65;
  localparam logic [7:0] TypePres   = 8'h66;
  localparam logic [7:0] TypeTemp   = 8'h67;
  localparam logic [7:0] TypeHum    = 8'h68;
  localparam logic [7:0] TypeAccel  = 8'h71;
  localparam logic [7:0] TypeBaro   = 8'h73;
  localparam logic [7:0] TypeGyro   = 8'h86;
  localparam logic [7:0] TypeGps    = 8'h88;

  typedef enum logic [1:0] {
    PH_CHAN = 2'd0,
    PH_TYPE = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_BAD     = 2'd3
  } status_e;

  typedef enum logic {
    KIND_RECORD = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  // One queue entry: what a single request produced
  typedef struct packed {
    logic               rec_valid;
    logic [ByteW-1:0]   channel;
    logic [ByteW-1:0]   rtype;
    logic [ValueW-1:0]  value_x;
    logic [ValueW-1:0]  value_y;
    logic [ValueW-1:0]  value_z;
    logic               sts_valid;
    status_e            status;
  } entry_t;

  // Data bytes per type; zero marks an unknown type
  function automatic logic [CountW-1:0] type_size(input logic [7:0] t);
    logic [CountW-1:0] n;
    unique case (t)
      TypeDigIn, TypeDigOut, TypePres:                       n = CountW'(1);
      TypeAnaIn, TypeAnaOut, TypeLum, TypeTemp, TypeHum, TypeBaro: n = CountW'(2);
      TypeAccel, TypeGyro:                                   n = CountW'(6);
      TypeGps:                                               n = CountW'(9);
      default:                                               n = '0;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/sprd_parser.sv
// Input register and record parser: one request per cycle into a result entry while the queue is not full.
module sprd_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sprd_pkg::ByteW-1:0]    in_byte_i,
  input  logic                          in_carry_i,
  input  logic                          in_end_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output sprd_pkg::entry_t              push_entry_o
);
  import sprd_pkg::*;

  // input register
  logic             iv_q;
  logic [ByteW-1:0] ib_q;
  logic             ic_q, ie_q;

  // parse state
  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  chan_q, chan_d;
  logic [ByteW-1:0]  type_q, type_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [ByteW-1:0]  bytes_q [MaxData];
  logic [ByteW-1:0]  bytes_d [MaxData];
  status_e           err_q, err_d;
  logic              any_q, any_d;

  logic consume;
  logic take;
  entry_t ent;

  assign consume    = iv_q && !q_full_i;
  assign in_ready_o = !iv_q || !q_full_i;
  assign take       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (in_ready_o) begin
      iv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ib_q <= in_byte_i;
      ic_q <= in_carry_i;
      ie_q <= in_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CHAN;
      chan_q  <= '0;
      type_q  <= '0;
      cnt_q   <= '0;
      err_q   <= ST_OK;
      any_q   <= 1'b0;
    end else if (consume) begin
      phase_q <= phase_d;
      chan_q  <= chan_d;
      type_q  <= type_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
      any_q   <= any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume) begin
      bytes_q <= bytes_d;
    end
  end

  always_comb begin
    logic              live;
    logic [CountW-1:0] need;
    logic [CountW-1:0] cnt_inc;
    logic              done;
    logic [ValueW-1:0] vx, vy, vz;
    status_e           st;

    phase_d = phase_q;
    chan_d  = chan_q;
    type_d  = type_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    any_d   = any_q || ic_q;
    live    = ic_q && (err_q == ST_OK);
    need    = type_size(type_q);
    cnt_inc = cnt_q + CountW'(1);
    done    = 1'b0;
    vx      = '0;
    vy      = '0;
    vz      = '0;
    st      = ST_OK;

    // capture the incoming data byte at its slot
    for (int i = 0; i < MaxData; i++) begin
      bytes_d[i] = (live && phase_q == PH_DATA && cnt_q == CountW'(i)) ? ib_q : bytes_q[i];
    end

    if (live) begin
      unique case (phase_q)
        PH_CHAN: begin
          chan_d  = ib_q;
          phase_d = PH_TYPE;
        end
        PH_TYPE: begin
          type_d = ib_q;
          cnt_d  = '0;
          if (type_size(ib_q) == '0) begin
            err_d = ST_UNKNOWN;
          end else begin
            phase_d = PH_DATA;
          end
        end
        PH_DATA: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= need) begin
            done    = 1'b1;
            phase_d = PH_CHAN;
            cnt_d   = '0;
          end
        end
        default: begin
          phase_d = PH_CHAN;
        end
      endcase
    end

    // big-endian value assembly by type
    unique case (type_q)
      TypeDigIn, TypeDigOut, TypePres: begin
        vx = {16'd0, bytes_d[0]};
      end
      TypeAnaIn, TypeAnaOut, TypeTemp: begin
        vx = {{8{bytes_d[0][7]}}, bytes_d[0], bytes_d[1]};
      end
      TypeLum, TypeHum, TypeBaro: begin
        vx = {8'd0, bytes_d[0], bytes_d[1]};
      end
      TypeAccel, TypeGyro: begin
        vx = {{8{bytes_d[0][7]}}, bytes_d[0], bytes_d[1]};
        vy = {{8{bytes_d[2][7]}}, bytes_d[2], bytes_d[3]};
        vz = {{8{bytes_d[4][7]}}, bytes_d[4], bytes_d[5]};
      end
      TypeGps: begin
        vx = {bytes_d[0], bytes_d[1], bytes_d[2]};
        vy = {bytes_d[3], bytes_d[4], bytes_d[5]};
        vz = {bytes_d[6], bytes_d[7], bytes_d[8]};
      end
      default: begin
        vx = '0;
      end
    endcase

    // payload end status, from the state after this byte
    if (!any_d) begin
      st = ST_EMPTY;
    end else if (err_d != ST_OK) begin
      st = err_d;
    end else if (phase_d != PH_CHAN) begin
      st = ST_BAD;
    end else begin
      st = ST_OK;
    end

    ent.rec_valid = done;
    ent.channel   = chan_q;
    ent.rtype     = type_q;
    ent.value_x   = vx;
    ent.value_y   = vy;
    ent.value_z   = vz;
    ent.sts_valid = ie_q;
    ent.status    = st;

    // return to the idle parse state after an end
    if (ie_q) begin
      phase_d = PH_CHAN;
      chan_d  = '0;
      type_d  = '0;
      cnt_d   = '0;
      err_d   = ST_OK;
      any_d   = 1'b0;
    end
  end

  assign push_o       = consume && (ent.rec_valid || ent.sts_valid);
  assign push_entry_o = ent;

`ifndef SYNTH
  a_data_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> err_q == ST_OK)
    else $error("data phase with error latched");
  a_cnt_below_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> cnt_q < type_size(type_q))
    else $error("data count reached record size");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full_i |-> !push_o)
    else $error("push into full queue");
`endif

endmodule

>>> rtl/sprd_out_queue.sv
// Two-entry result queue that sends each entry as a record and/or status result.
module sprd_out_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  sprd_pkg::entry_t                 push_entry_i,
  output logic                             full_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sprd_pkg::OutDataW-1:0]    out_data_o,
  output logic [sprd_pkg::OutUserW-1:0]    out_user_o,
  output logic                             out_last_o
);
  import sprd_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  entry_t          ent_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            sub_q;   // record of the head entry already sent
  entry_t          head;
  logic            show_rec;
  logic            fire, pop;

  assign head        = ent_q[rd_q];
  assign out_valid_o = cnt_q != '0;
  assign full_o      = cnt_q == CntW'(QueueDepth);
  assign show_rec    = head.rec_valid && !sub_q;
  assign fire        = out_valid_o && out_ready_i;
  assign pop         = fire && (!show_rec || !head.sts_valid);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
      sub_q <= 1'b0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop);
      if (pop) begin
        sub_q <= 1'b0;
      end else if (fire) begin
        sub_q <= 1'b1;
      end
    end
  end

  always_comb begin
    out_data_o = '0;
    if (show_rec) begin
      out_data_o[OutFieldW-1:0] = {ST_OK, head.value_z, head.value_y, head.value_x,
                                   head.rtype, head.channel};
      out_user_o = OutUserW'(KIND_RECORD);
      out_last_o = 1'b0;
    end else begin
      out_data_o[OutFieldW-1:0] = {head.status, {(3 * ValueW + 2 * ByteW){1'b0}}};
      out_user_o = OutUserW'(KIND_STATUS);
      out_last_o = 1'b1;
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth))
    else $error("queue count overflow");
  a_sub_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q |-> (out_valid_o && head.rec_valid && head.sts_valid))
    else $error("split entry without record and status");
  a_head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (head.rec_valid || head.sts_valid))
    else $error("queue holds an empty entry");
`endif

endmodule

>>> rtl/sensor_payload_record_decoder.sv
// Top level of the sensor payload record decoder: byte stream in, records and status out.
//
// Usage:
//   Slave stream: one payload byte per request. tdata[7:0] is the byte, tuser[0] says
//   the byte is present, tlast ends the payload (a byte on the same request is parsed
//   first). A request with neither tuser[0] nor tlast does nothing.
//   Master stream: tuser[0] = 0 is a decoded record (channel, type, up to three raw
//   big-endian values, sign-extended per type); tuser[0] = 1 with tlast is the final
//   status of the payload (ok, empty, unknown type, bad format). Drop the records of a
//   payload whose status is not ok; bytes after an error are ignored.
// Path: each request passes the input register, then a result queue entry, before
//   its record or status appears at the output.
// Throughput: one request per cycle while the receiver keeps up. A request that ends
//   a record and the payload at once yields two results, sent one after the other from
//   one queue entry; the two-entry result queue sets how far input runs ahead.
// Stall: when the receiver holds tready low, the queue fills and tready on the input
//   drops; nothing is lost or repeated.
// Reset: rst_ni clears the parse state and empties the queue; the decoder then
//   expects a channel byte.
module sensor_payload_record_decoder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [7:0] data_byte
  input  logic [sprd_pkg::InDataW-1:0]        s_axis_tdata_i,
  // [0] carries_byte
  input  logic [sprd_pkg::InUserW-1:0]        s_axis_tuser_i,
  // end_of_payload
  input  logic                                s_axis_tlast_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [7:0] record_channel, [15:8] record_type, [39:16] value_x, [63:40] value_y,
  // [87:64] value_z, [89:88] payload_status, [95:90] zero
  output logic [sprd_pkg::OutDataW-1:0]       m_axis_tdata_o,
  // [0] result_kind
  output logic [sprd_pkg::OutUserW-1:0]       m_axis_tuser_o,
  // last_of_payload
  output logic                                m_axis_tlast_o
);
  import sprd_pkg::*;

  logic   push;
  logic   full;
  entry_t push_entry;

  // parse one request per cycle into a queue entry while the queue has room
  sprd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_byte_i    (s_axis_tdata_i[ByteW-1:0]),
    .in_carry_i   (s_axis_tuser_i[0]),
    .in_end_i     (s_axis_tlast_i),
    .q_full_i     (full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  // hold results until the receiver takes them
  sprd_out_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_data_o   (m_axis_tdata_o),
    .out_user_o   (m_axis_tuser_o),
    .out_last_o   (m_axis_tlast_o)
  );

endmodule
